// ===== design/ovca_pkg.sv =====
`timescale 1ns / 1ps

package ovca_pkg;

  // Sizing of the port
  localparam int NUM_VNETS      = 4;
  localparam int VC_PER_VNET    = 4;
  localparam int BUFFERS_PER_VC = 4;
  localparam int NUM_CH         = NUM_VNETS * VC_PER_VNET;

  // Field widths
  localparam int OP_W     = 2;
  localparam int VNET_W   = 2;
  localparam int CHOICE_W = 3;
  localparam int CH_W     = 4;
  localparam int RCNT_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Internal widths
  localparam int CH_IDX_W = $clog2(NUM_CH);
  localparam int CRED_W   = $clog2(BUFFERS_PER_VC + 1);
  localparam int OFF_W    = $clog2(VC_PER_VNET);
  localparam int RNG_W    = $clog2(VC_PER_VNET + 1);

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
  localparam logic [OP_W-1:0] OP_FLIT   = 2'd2;
  localparam logic [OP_W-1:0] OP_CREDIT = 2'd3;

  // Search range choices
  localparam logic [CHOICE_W-1:0] CH_LOW      = 3'd0;
  localparam logic [CHOICE_W-1:0] CH_HIGH     = 3'd1;
  localparam logic [CHOICE_W-1:0] CH_NORM_LOW = 3'd2;
  localparam logic [CHOICE_W-1:0] CH_NORM_HI  = 3'd3;
  localparam logic [CHOICE_W-1:0] CH_WHOLE    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RSV_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RSV_COUNT = 2'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the input item
    logic exec;   // run the item against the channel state
  } ovca_cmd_t;

endpackage

// ===== design/ovca_ctrl.sv =====
`timescale 1ns / 1ps

module ovca_ctrl
  import ovca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ovca_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   valid_q, valid_d;

  // Next state and registered handshake outputs
  always_comb begin
    state_d = state_q;
    stall_d = stall_q;
    valid_d = valid_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
          stall_d = 1'b1;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        valid_d = 1'b1;
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
          valid_d = 1'b0;
          stall_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        valid_d = 1'b0;
        stall_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
      valid_q <= valid_d;
    end
  end

  assign in_stall_o   = stall_q;
  assign out_valid_o  = valid_q;
  assign cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec   = (state_q == S_EXEC);

endmodule

// ===== design/ovca_dp.sv =====
`timescale 1ns / 1ps

module ovca_dp
  import ovca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ovca_cmd_t             cmd_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [VNET_W-1:0]     vnet_i,
  input  logic [CHOICE_W-1:0]   choice_i,
  input  logic [CH_W-1:0]       channel_i,
  input  logic                  free_flag_i,
  output logic                  found_o,
  output logic [CH_W-1:0]       vc_index_o,
  output logic                  credit_ok_o,
  output logic                  error_o
);

  // Configuration
  logic              rsv_mode_q;
  logic [RCNT_W-1:0] rsv_count_q;

  // Captured item
  logic [OP_W-1:0]     op_q;
  logic [VNET_W-1:0]   vnet_q;
  logic [CHOICE_W-1:0] choice_q;
  logic [CH_W-1:0]     channel_q;
  logic                free_q;

  // Channel state
  logic [NUM_CH-1:0] active_q;
  logic [CRED_W-1:0] credit_q [NUM_CH];

  // Result register
  logic            found_q;
  logic [CH_W-1:0] vc_index_q;
  logic            credit_ok_q;
  logic            error_q;

  // Search and update signals
  logic                split;
  logic [RNG_W-1:0]    r_eff;
  logic [RNG_W-1:0]    mid;
  logic [RNG_W-1:0]    lo;
  logic [RNG_W-1:0]    hi;
  logic                choice_ok;
  logic                vnet_ok;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] base;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                hit;
  logic [OFF_W-1:0]    hit_off;
  logic [CH_IDX_W-1:0] hit_idx;
  logic [CRED_W-1:0]   cred_cur;
  logic [CRED_W-1:0]   cred_new;
  logic                found_d;
  logic                error_d;
  logic                alloc_set;
  logic                cred_we;
  logic                free_clr;

  // Configuration writes; other indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_mode_q  <= 1'b0;
      rsv_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_RSV_MODE) begin
        rsv_mode_q <= cfg_data_i[0];
      end else if (cfg_index_i == CFG_RSV_COUNT) begin
        rsv_count_q <= cfg_data_i[RCNT_W-1:0];
      end
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= opcode_i;
      vnet_q    <= vnet_i;
      choice_q  <= choice_i;
      channel_q <= channel_i;
      free_q    <= free_flag_i;
    end
  end

  // Search range within the virtual network
  always_comb begin
    split = rsv_mode_q && (rsv_count_q != '0);
    if (32'(rsv_count_q) > VC_PER_VNET) begin
      r_eff = RNG_W'(VC_PER_VNET);
    end else begin
      r_eff = RNG_W'(rsv_count_q);
    end
    mid       = RNG_W'((32'(r_eff) + VC_PER_VNET) >> 1);
    lo        = '0;
    hi        = '0;
    choice_ok = 1'b1;
    case (choice_q)
      CH_LOW: begin
        hi = RNG_W'(VC_PER_VNET / 2);
      end
      CH_HIGH: begin
        lo = RNG_W'(VC_PER_VNET / 2);
        hi = RNG_W'(VC_PER_VNET);
      end
      CH_NORM_LOW: begin
        choice_ok = split;
        lo        = r_eff;
        hi        = mid;
      end
      CH_NORM_HI: begin
        choice_ok = split;
        lo        = mid;
        hi        = RNG_W'(VC_PER_VNET);
      end
      CH_WHOLE: begin
        hi = RNG_W'(VC_PER_VNET);
      end
      default: begin
        choice_ok = 1'b0;
      end
    endcase
  end

  assign vnet_ok = 32'(vnet_q) < NUM_VNETS;
  assign ch_ok   = 32'(channel_q) < NUM_CH;
  assign base    = CH_IDX_W'(32'(vnet_q) * VC_PER_VNET);
  assign ch_idx  = CH_IDX_W'(channel_q);

  // Lowest idle channel inside the range: masked priority encoder
  always_comb begin
    hit     = 1'b0;
    hit_off = '0;
    for (int k = VC_PER_VNET - 1; k >= 0; k--) begin
      if ((k >= int'(lo)) && (k < int'(hi)) &&
          !active_q[CH_IDX_W'(32'(base) + k)]) begin
        hit     = 1'b1;
        hit_off = OFF_W'(k);
      end
    end
  end

  assign hit_idx = CH_IDX_W'(32'(base) + 32'(hit_off));

  // Execution of the captured item
  always_comb begin
    cred_cur  = credit_q[ch_idx];
    cred_new  = cred_cur;
    found_d   = 1'b0;
    error_d   = 1'b0;
    alloc_set = 1'b0;
    cred_we   = 1'b0;
    free_clr  = 1'b0;
    case (op_q)
      OP_ALLOC, OP_PROBE: begin
        if (!vnet_ok || !choice_ok) begin
          error_d = 1'b1;
        end else begin
          found_d   = hit;
          alloc_set = hit && (op_q == OP_ALLOC);
        end
      end
      OP_FLIT: begin
        if (!ch_ok) begin
          error_d = 1'b1;
        end else if (cred_cur == '0) begin
          error_d = 1'b1;
        end else begin
          cred_new = cred_cur - CRED_W'(1);
          cred_we  = 1'b1;
        end
      end
      OP_CREDIT: begin
        if (!ch_ok) begin
          error_d = 1'b1;
        end else begin
          if (32'(cred_cur) >= BUFFERS_PER_VC) begin
            error_d = 1'b1;
          end else begin
            cred_new = cred_cur + CRED_W'(1);
            cred_we  = 1'b1;
          end
          free_clr = free_q;
        end
      end
      default: begin
        error_d = 1'b1;
      end
    endcase
  end

  // Channel state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        credit_q[i] <= CRED_W'(BUFFERS_PER_VC);
      end
    end else if (cmd_i.exec) begin
      if (alloc_set) begin
        active_q[hit_idx] <= 1'b1;
      end
      if (free_clr) begin
        active_q[ch_idx] <= 1'b0;
      end
      if (cred_we) begin
        credit_q[ch_idx] <= cred_new;
      end
    end
  end

  // Result register, held until the item is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      found_q     <= found_d;
      vc_index_q  <= alloc_set ? CH_W'(hit_idx) : '0;
      credit_ok_q <= ch_ok && (cred_new != '0);
      error_q     <= error_d;
    end
  end

  assign found_o     = found_q;
  assign vc_index_o  = vc_index_q;
  assign credit_ok_o = credit_ok_q;
  assign error_o     = error_q;

endmodule

// ===== design/output_vc_allocator_with_credits.sv =====
`timescale 1ns / 1ps

// Output virtual channel allocator with credit tracking for one router port.
// Input channel (in_valid_i / in_stall_o) carries one item: allocate, probe,
// flit sent or credit return, with vnet, choice, channel and free_flag.
// Output channel (out_valid_o / out_stall_i) returns exactly one result item
// per input item: found, vc_index, credit_ok and error.
// Configuration port (cfg_valid_i / cfg_ready_o) writes reserved_mode at
// index 0 and reserved_count at index 1; it is always ready. It must be
// written only while no item is in flight; the block does not enforce this.
// An accepted item is captured, then executed, and its result is registered
// and shown on the output until it is taken. One item is in flight at a time,
// set by the controller's three-step sequence (capture, execute, hand over)
// around the single state update port.
// While the receiver stalls, the result is held and in_stall_o stays high.
// Reset (rst_ni low, asynchronous) marks every channel idle, sets every
// credit count to the buffer depth and clears both registers; the block
// accepts items as soon as reset is released.

module output_vc_allocator_with_credits
  import ovca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       in_opcode_i,
  input  logic [VNET_W-1:0]     in_vnet_i,
  input  logic [CHOICE_W-1:0]   in_choice_i,
  input  logic [CH_W-1:0]       in_channel_i,
  input  logic                  in_free_flag_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_found_o,
  output logic [CH_W-1:0]       out_vc_index_o,
  output logic                  out_credit_ok_o,
  output logic                  out_error_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ovca_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  ovca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Channel state, search and result
  ovca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .opcode_i    (in_opcode_i),
    .vnet_i      (in_vnet_i),
    .choice_i    (in_choice_i),
    .channel_i   (in_channel_i),
    .free_flag_i (in_free_flag_i),
    .found_o     (out_found_o),
    .vc_index_o  (out_vc_index_o),
    .credit_ok_o (out_credit_ok_o),
    .error_o     (out_error_o)
  );

endmodule

// ===== design/ovca_checker.sv =====
`timescale 1ns / 1ps

module ovca_assertions
  import ovca_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_i,
  input logic            out_valid_i,
  input logic            out_stall_i,
  input logic            out_found_i,
  input logic [CH_W-1:0] out_vc_index_i,
  input logic            out_credit_ok_i,
  input logic            out_error_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_found_i) &&
      $stable(out_vc_index_i) && $stable(out_credit_ok_i) && $stable(out_error_i))
    else $error("stalled result changed");

  // One item at a time: after acceptance the input side is stalled
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input accepted while an item is in flight");

  // A taken result is not repeated
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i |=> !out_valid_i)
    else $error("result repeated");

  // No result without a pending item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> in_stall_i)
    else $error("result without an accepted item");

  // A failed search never names a channel
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (!out_found_i || out_error_i) |-> out_vc_index_i == '0)
    else $error("channel index given without a found channel");

endmodule

bind output_vc_allocator_with_credits ovca_assertions u_ovca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_found_i     (out_found_o),
  .out_vc_index_i  (out_vc_index_o),
  .out_credit_ok_i (out_credit_ok_o),
  .out_error_i     (out_error_o)
);

// ===== test/ovca_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register channels of the VC allocator, keeps
// its own copy of the channel state and checks every result item in order.
module ovca_checker
  import ovca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [OP_W-1:0]       in_opcode_i,
  input  logic [VNET_W-1:0]     in_vnet_i,
  input  logic [CHOICE_W-1:0]   in_choice_i,
  input  logic [CH_W-1:0]       in_channel_i,
  input  logic                  in_free_flag_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  out_found_i,
  input  logic [CH_W-1:0]       out_vc_index_i,
  input  logic                  out_credit_ok_i,
  input  logic                  out_error_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [31:0]           fail_count_o,
  output logic [31:0]           reports_waiting_o
);

  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] vc_index;
    logic            credit_ok;
    logic            error;
  } port_report_t;

  // Shadow of the port state
  logic              rsv_mode;
  logic [RCNT_W-1:0] rsv_count;
  logic              vc_busy   [NUM_CH];
  logic [CRED_W-1:0] vc_credit [NUM_CH];

  port_report_t report_q [$];
  port_report_t want;

  // Runs one item against the shadow state and returns the report it should give
  function automatic port_report_t apply_port_op(
    logic [OP_W-1:0]     op,
    logic [VNET_W-1:0]   vnet,
    logic [CHOICE_W-1:0] choice,
    logic [CH_W-1:0]     ch,
    logic                free_flag
  );
    port_report_t rep;
    int   lo, hi, rsv, base, vc, k;
    logic split, legal;
    rep   = '0;
    lo    = 0;
    hi    = 0;
    legal = 1'b1;
    split = rsv_mode && (rsv_count != 0);
    rsv   = (int'(rsv_count) > VC_PER_VNET) ? VC_PER_VNET : int'(rsv_count);
    if (op == OP_ALLOC || op == OP_PROBE) begin
      // search window within the vnet
      case (choice)
        CH_LOW: begin
          lo = 0;
          hi = VC_PER_VNET / 2;
        end
        CH_HIGH: begin
          lo = VC_PER_VNET / 2;
          hi = VC_PER_VNET;
        end
        CH_NORM_LOW: begin
          legal = split;
          lo    = rsv;
          hi    = (rsv + VC_PER_VNET) / 2;
        end
        CH_NORM_HI: begin
          legal = split;
          lo    = (rsv + VC_PER_VNET) / 2;
          hi    = VC_PER_VNET;
        end
        CH_WHOLE: begin
          lo = 0;
          hi = VC_PER_VNET;
        end
        default: legal = 1'b0;
      endcase
      if (int'(vnet) >= NUM_VNETS || !legal) begin
        rep.error = 1'b1;
      end else begin
        // lowest idle channel wins
        base = int'(vnet) * VC_PER_VNET;
        for (k = lo; k < hi; k++) begin
          vc = base + k;
          if (!rep.found && vc < NUM_CH && !vc_busy[vc]) begin
            rep.found = 1'b1;
            if (op == OP_ALLOC) begin
              vc_busy[vc]  = 1'b1;
              rep.vc_index = CH_W'(vc);
            end
          end
        end
      end
    end else if (int'(ch) >= NUM_CH) begin
      rep.error = 1'b1;
    end else if (op == OP_FLIT) begin
      // credit taken, sticks at zero
      if (vc_credit[ch] == 0) rep.error = 1'b1;
      else vc_credit[ch] = vc_credit[ch] - 1'b1;
    end else begin
      // credit returned, sticks at full; free still applies
      if (vc_credit[ch] >= BUFFERS_PER_VC) rep.error = 1'b1;
      else vc_credit[ch] = vc_credit[ch] + 1'b1;
      if (free_flag) vc_busy[ch] = 1'b0;
    end
    rep.credit_ok = (int'(ch) < NUM_CH) && (vc_credit[ch] != 0);
    return rep;
  endfunction

  // Observe all three channels at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsv_mode  = 1'b0;
      rsv_count = '0;
      for (int i = 0; i < NUM_CH; i++) begin
        vc_busy[i]   = 1'b0;
        vc_credit[i] = CRED_W'(BUFFERS_PER_VC);
      end
      report_q.delete();
      fail_count_o = '0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RSV_MODE:  rsv_mode  = cfg_data_i[0];
          CFG_RSV_COUNT: rsv_count = cfg_data_i[RCNT_W-1:0];
          default: ;
        endcase
      end
      // result items against the oldest report
      if (out_valid_i && !out_stall_i) begin
        if (report_q.size() == 0) begin
          $error("result item with no report awaited");
          fail_count_o = fail_count_o + 1;
        end else begin
          want = report_q.pop_front();
          if (out_found_i !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_found_i);
            fail_count_o = fail_count_o + 1;
          end
          if (out_vc_index_i !== want.vc_index) begin
            $error("vc_index: expected %0d, got %0d", want.vc_index, out_vc_index_i);
            fail_count_o = fail_count_o + 1;
          end
          if (out_credit_ok_i !== want.credit_ok) begin
            $error("credit_ok: expected %0d, got %0d", want.credit_ok, out_credit_ok_i);
            fail_count_o = fail_count_o + 1;
          end
          if (out_error_i !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, out_error_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      // accepted items go to the tail of the report queue
      if (in_valid_i && !in_stall_i) begin
        report_q.insert(report_q.size(),
                        apply_port_op(in_opcode_i, in_vnet_i, in_choice_i,
                                      in_channel_i, in_free_flag_i));
      end
    end
    reports_waiting_o = report_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ovca_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int ITEMS_PER_SET = 92;
  localparam int NUM_SETS      = 6;
  localparam int HOLD_AT       = 450;
  localparam int HOLD_LEN      = 60;
  localparam int DRAIN_CYCLES  = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OP_W-1:0]       in_opcode_i;
  logic [VNET_W-1:0]     in_vnet_i;
  logic [CHOICE_W-1:0]   in_choice_i;
  logic [CH_W-1:0]       in_channel_i;
  logic                  in_free_flag_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  out_found_o;
  logic [CH_W-1:0]       out_vc_index_o;
  logic                  out_credit_ok_o;
  logic                  out_error_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [31:0] fail_count;
  logic [31:0] reports_waiting;

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int cycle_count;

  // register settings per random set: {mode, count}
  logic                  set_mode  [NUM_SETS] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  logic [CFG_DATA_W-1:0] set_count [NUM_SETS] = '{3'd1, 3'd0, 3'd4, 3'd3, 3'd2, 3'd7};

  output_vc_allocator_with_credits i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_opcode_i    (in_opcode_i),
    .in_vnet_i      (in_vnet_i),
    .in_choice_i    (in_choice_i),
    .in_channel_i   (in_channel_i),
    .in_free_flag_i (in_free_flag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_found_o    (out_found_o),
    .out_vc_index_o (out_vc_index_o),
    .out_credit_ok_o(out_credit_ok_o),
    .out_error_o    (out_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  ovca_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_opcode_i      (in_opcode_i),
    .in_vnet_i        (in_vnet_i),
    .in_choice_i      (in_choice_i),
    .in_channel_i     (in_channel_i),
    .in_free_flag_i   (in_free_flag_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_found_i      (out_found_o),
    .out_vc_index_i   (out_vc_index_o),
    .out_credit_ok_i  (out_credit_ok_o),
    .out_error_i      (out_error_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .reports_waiting_o(reports_waiting)
  );

  // 125 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result receiver: random stalls plus one long hold-off to back up the port
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one item after random gaps; returns at the falling edge after accept
  task automatic send_item(
    input logic [OP_W-1:0]     op,
    input logic [VNET_W-1:0]   vnet,
    input logic [CHOICE_W-1:0] choice,
    input logic [CH_W-1:0]     ch,
    input logic                free_flag
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    in_opcode_i    = op;
    in_vnet_i      = vnet;
    in_choice_i    = choice;
    in_channel_i   = ch;
    in_free_flag_i = free_flag;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Random item: mostly legal windows, some illegal choices
  task automatic send_random_item();
    int                  pick;
    logic [OP_W-1:0]     op;
    logic [CHOICE_W-1:0] choice;
    pick = $urandom_range(99);
    if (pick < 30)      op = OP_ALLOC;
    else if (pick < 45) op = OP_PROBE;
    else if (pick < 70) op = OP_FLIT;
    else                op = OP_CREDIT;
    if ($urandom_range(9) == 0) choice = CHOICE_W'($urandom_range((1 << CHOICE_W) - 1));
    else                        choice = CHOICE_W'($urandom_range(CH_WHOLE));
    send_item(op, VNET_W'($urandom_range((1 << VNET_W) - 1)), choice,
              CH_W'($urandom_range((1 << CH_W) - 1)), 1'($urandom_range(1)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Stop offering and wait until every report is in
  task automatic drain();
    in_valid_i = 1'b0;
    while (reports_waiting != 0) @(negedge clk_i);
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_opcode_i    = OP_ALLOC;
    in_vnet_i      = '0;
    in_choice_i    = CH_LOW;
    in_channel_i   = '0;
    in_free_flag_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_RSV_MODE;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    items_sent     = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: plain mode
    write_reg(CFG_RSV_MODE, '0);
    write_reg(CFG_RSV_COUNT, '0);
    send_item(OP_ALLOC, 0, CH_WHOLE, 0, 1'b0);
    send_item(OP_PROBE, 0, CH_LOW, 15, 1'b1);
    send_item(OP_ALLOC, 0, CH_LOW, 0, 1'b0);
    send_item(OP_ALLOC, 0, CH_LOW, 15, 1'b0);     // low half exhausted
    send_item(OP_ALLOC, 3, CH_HIGH, 15, 1'b1);
    send_item(OP_ALLOC, 3, CH_NORM_LOW, 0, 1'b0); // needs split mode
    send_item(OP_PROBE, 3, CH_NORM_HI, 0, 1'b0);  // needs split mode
    send_item(OP_ALLOC, 1, CHOICE_W'(CH_WHOLE + 3'd1), 0, 1'b0);
    send_item(OP_PROBE, 2, {CHOICE_W{1'b1}}, 0, 1'b0);
    repeat (5) send_item(OP_FLIT, 0, CH_LOW, 0, 1'b0); // last one underflows
    send_item(OP_CREDIT, 0, CH_LOW, 0, 1'b0);
    send_item(OP_CREDIT, 3, CH_LOW, 15, 1'b1);    // overflow, still freed
    send_item(OP_CREDIT, 0, CH_LOW, 1, 1'b1);
    send_item(OP_ALLOC, 0, CH_WHOLE, 1, 1'b0);
    drain();

    // Directed: split mode with an oversized reserve, then a small one
    write_reg(CFG_RSV_MODE, 3'd1);
    write_reg(CFG_RSV_COUNT, 3'd7);
    send_item(OP_ALLOC, 2, CH_NORM_LOW, 8, 1'b0);  // empty window
    send_item(OP_PROBE, 2, CH_NORM_HI, 9, 1'b0);   // empty window
    drain();
    write_reg(CFG_RSV_COUNT, 3'd1);
    send_item(OP_ALLOC, 2, CH_NORM_LOW, 9, 1'b0);
    send_item(OP_ALLOC, 2, CH_NORM_HI, 10, 1'b0);
    send_item(OP_PROBE, 2, CH_NORM_LOW, 9, 1'b0);
    drain();

    // Random sets: sender idles lightly, then receiver lightly, then neither
    for (int s = 0; s < NUM_SETS; s++) begin
      drain();
      case (s / 2)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(CFG_RSV_MODE, CFG_DATA_W'(set_mode[s]));
      write_reg(CFG_RSV_COUNT, set_count[s]);
      repeat (ITEMS_PER_SET) send_random_item();
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== output_vc_allocator_with_credits.f =====
design/ovca_pkg.sv
design/ovca_ctrl.sv
design/ovca_dp.sv
design/output_vc_allocator_with_credits.sv
design/ovca_checker.sv
test/ovca_checker.sv
test/testbench.sv
